// ===== rtl/assert_macros.svh =====
// Assertion macros for the checker file of the key/value table.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge outside reset.
`define AKVT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: assertion failed");

// Property checked on every rising edge, reset included.
`define AKVT_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("%m: assertion failed");

`endif

// ===== rtl/akvt_pkg.sv =====
// Shared types and constants for the associative key/value table.
// No dependencies.
package akvt_pkg;

  localparam int ENTRIES_DEF    = 16;
  localparam int KEY_BITS_DEF   = 64;
  localparam int VALUE_BITS_DEF = 64;
  localparam int FIELD_BITS     = 64;
  localparam int COUNT_BITS     = 5;

  typedef enum logic [1:0] {
    MODE_CLEAR  = 2'd0,
    MODE_SET    = 2'd1,
    MODE_REMOVE = 2'd2,
    MODE_GET    = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_FULL    = 2'd1,
    STATUS_MISSING = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_APPLY,
    S_RESP
  } state_t;

  typedef struct packed {
    mode_t                  mode;
    logic [FIELD_BITS-1:0]  key;
    logic [FIELD_BITS-1:0]  value;
  } in_req_t;

  typedef struct packed {
    status_t                status;
    logic [FIELD_BITS-1:0]  found_value;
    logic [COUNT_BITS-1:0]  count;
  } out_rsp_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic rd_en;
    logic apply;
    logic resp_load;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic scan_req;
    logic idx_last;
    logic out_busy;
  } dp_sts_t;

endpackage

// ===== rtl/akvt_ctrl.sv =====
// Sequencing state machine for the key/value table.
// Depends on akvt_pkg.
module akvt_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  output akvt_pkg::dp_cmd_t cmd,
  input  akvt_pkg::dp_sts_t sts
);

  akvt_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= akvt_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    in_stall      = 1'b1;
    case (state_r)
      akvt_pkg::S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          // clear and empty-key requests need no lookup
          state_nxt = sts.scan_req ? akvt_pkg::S_SCAN : akvt_pkg::S_APPLY;
        end
      end
      akvt_pkg::S_SCAN: begin
        cmd.rd_en = 1'b1;
        if (sts.idx_last) begin
          state_nxt = akvt_pkg::S_DRAIN;
        end
      end
      akvt_pkg::S_DRAIN: begin
        state_nxt = akvt_pkg::S_APPLY;
      end
      akvt_pkg::S_APPLY: begin
        cmd.apply = 1'b1;
        state_nxt = akvt_pkg::S_RESP;
      end
      akvt_pkg::S_RESP: begin
        // hold until the output register is free
        if (!sts.out_busy) begin
          cmd.resp_load = 1'b1;
          state_nxt     = akvt_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = akvt_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/akvt_dp.sv =====
// Datapath of the key/value table: key and value memories, scan compare,
// occupancy count and the output register. Depends on akvt_pkg.
module akvt_dp #(
  parameter int ENTRIES    = akvt_pkg::ENTRIES_DEF,
  parameter int KEY_BITS   = akvt_pkg::KEY_BITS_DEF,
  parameter int VALUE_BITS = akvt_pkg::VALUE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  akvt_pkg::in_req_t  in_data,
  input  logic               out_stall,
  output logic               out_valid,
  output akvt_pkg::out_rsp_t out_data,
  input  akvt_pkg::dp_cmd_t  cmd,
  output akvt_pkg::dp_sts_t  sts
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);

  // request registers
  akvt_pkg::mode_t        mode_r;
  logic [KEY_BITS-1:0]    key_r;
  logic [VALUE_BITS-1:0]  value_r;

  // scan
  logic [IDX_W-1:0]       idx_r;
  logic                   rd_vld_r;
  logic [IDX_W-1:0]       rd_idx_r;
  logic [KEY_BITS-1:0]    key_rd_r;
  logic                   vld_rd_r;
  logic                   hit_r;
  logic [IDX_W-1:0]       hit_idx_r;
  logic                   free_r;
  logic [IDX_W-1:0]       free_idx_r;

  // storage
  logic [KEY_BITS-1:0]    key_mem   [ENTRIES];
  logic [VALUE_BITS-1:0]  val_mem   [ENTRIES];
  logic [ENTRIES-1:0]     vld_r;
  logic [VALUE_BITS-1:0]  val_rd_r;
  logic [CNT_W-1:0]       count_r;

  // result
  akvt_pkg::status_t      res_status_r;
  logic                   res_get_r;
  logic                   out_valid_r;
  akvt_pkg::out_rsp_t     out_data_r;

  logic                   key_zero;
  logic                   do_insert;
  logic                   do_update;
  logic                   do_remove;

  assign key_zero     = (key_r == '0);
  assign sts.scan_req = (in_data.mode != akvt_pkg::MODE_CLEAR) &&
                        (in_data.key[KEY_BITS-1:0] != '0);
  assign sts.idx_last = (idx_r == IDX_W'(ENTRIES - 1));
  assign sts.out_busy = out_valid_r && out_stall;

  assign do_update = cmd.apply && !key_zero && (mode_r == akvt_pkg::MODE_SET) && hit_r;
  assign do_insert = cmd.apply && !key_zero && (mode_r == akvt_pkg::MODE_SET) &&
                     !hit_r && free_r;
  assign do_remove = cmd.apply && !key_zero && (mode_r == akvt_pkg::MODE_REMOVE) && hit_r;

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r  <= in_data.mode;
      key_r   <= in_data.key[KEY_BITS-1:0];
      value_r <= in_data.value[VALUE_BITS-1:0];
    end
    if (cmd.rd_en) begin
      key_rd_r <= key_mem[idx_r];
      vld_rd_r <= vld_r[idx_r];
    end
    rd_idx_r <= idx_r;
    if (do_insert) begin
      key_mem[free_idx_r] <= key_r;
    end
    if (do_insert) begin
      val_mem[free_idx_r] <= value_r;
    end else if (do_update) begin
      val_mem[hit_idx_r] <= value_r;
    end
    val_rd_r <= val_mem[hit_idx_r];
    if (cmd.resp_load) begin
      out_data_r.status      <= res_status_r;
      out_data_r.found_value <= res_get_r ? akvt_pkg::FIELD_BITS'(val_rd_r) : '0;
      out_data_r.count       <= akvt_pkg::COUNT_BITS'(count_r);
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r        <= '0;
      rd_vld_r     <= 1'b0;
      hit_r        <= 1'b0;
      hit_idx_r    <= '0;
      free_r       <= 1'b0;
      free_idx_r   <= '0;
      vld_r        <= '0;
      count_r      <= '0;
      res_status_r <= akvt_pkg::STATUS_OK;
      res_get_r    <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      rd_vld_r <= cmd.rd_en;
      if (cmd.load) begin
        idx_r  <= '0;
        hit_r  <= 1'b0;
        free_r <= 1'b0;
      end else if (cmd.rd_en && !sts.idx_last) begin
        idx_r <= idx_r + 1'b1;
      end
      // keep the lowest matching slot and the lowest empty slot
      if (rd_vld_r) begin
        if (vld_rd_r && (key_rd_r == key_r) && !hit_r) begin
          hit_r     <= 1'b1;
          hit_idx_r <= rd_idx_r;
        end
        if (!vld_rd_r && !free_r) begin
          free_r     <= 1'b1;
          free_idx_r <= rd_idx_r;
        end
      end
      if (cmd.apply) begin
        res_get_r <= 1'b0;
        if (mode_r == akvt_pkg::MODE_CLEAR) begin
          vld_r        <= '0;
          count_r      <= '0;
          res_status_r <= akvt_pkg::STATUS_OK;
        end else if (key_zero) begin
          res_status_r <= (mode_r == akvt_pkg::MODE_SET) ? akvt_pkg::STATUS_FULL
                                                         : akvt_pkg::STATUS_MISSING;
        end else if (mode_r == akvt_pkg::MODE_SET) begin
          if (hit_r) begin
            res_status_r <= akvt_pkg::STATUS_OK;
          end else if (free_r) begin
            vld_r[free_idx_r] <= 1'b1;
            count_r           <= count_r + 1'b1;
            res_status_r      <= akvt_pkg::STATUS_OK;
          end else begin
            res_status_r <= akvt_pkg::STATUS_FULL;
          end
        end else if (!hit_r) begin
          res_status_r <= akvt_pkg::STATUS_MISSING;
        end else if (do_remove) begin
          vld_r[hit_idx_r] <= 1'b0;
          if (count_r != '0) begin
            count_r <= count_r - 1'b1;
          end
          res_status_r <= akvt_pkg::STATUS_OK;
        end else begin
          res_get_r    <= 1'b1;
          res_status_r <= akvt_pkg::STATUS_OK;
        end
      end
      if (cmd.resp_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== rtl/associative_key_value_table.sv =====
// Fully associative key/value table. Get, set and remove requests are accepted,
// then scan the table one slot per cycle through the key memory read port, drain
// the read, apply and respond; clear and empty-key requests go straight to apply
// and respond. The output register holds a result while the next request is taken,
// and a stalled result holds the next one back.
// Reset (rst_n low, synchronous) empties every slot at once and zeroes the count.
module associative_key_value_table #(
  parameter int ENTRIES    = akvt_pkg::ENTRIES_DEF,
  parameter int KEY_BITS   = akvt_pkg::KEY_BITS_DEF,
  parameter int VALUE_BITS = akvt_pkg::VALUE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  akvt_pkg::in_req_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output akvt_pkg::out_rsp_t out_data
);

  akvt_pkg::dp_cmd_t cmd;
  akvt_pkg::dp_sts_t sts;

  akvt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .sts      (sts)
  );

  akvt_dp #(
    .ENTRIES    (ENTRIES),
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

// ===== rtl/akvt_chk.sv =====
// Port-level checker for the key/value table, bound to the top level.
// Depends on akvt_pkg and assert_macros.svh.
`include "assert_macros.svh"

module akvt_chk (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input akvt_pkg::out_rsp_t out_data
);

  logic rsp_err;

  assign rsp_err = (out_data.status != akvt_pkg::STATUS_OK);

  `AKVT_ASSERT_ALWAYS(a_rst_no_out, !rst_n |=> !out_valid)
  `AKVT_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_data))
  `AKVT_ASSERT(a_busy_after_req, in_valid && !in_stall |=> in_stall)
  `AKVT_ASSERT(a_value_only_ok, out_valid && rsp_err |-> out_data.found_value == '0)
  `AKVT_ASSERT(a_status_code, out_valid |-> out_data.status <= akvt_pkg::STATUS_MISSING)

endmodule

bind associative_key_value_table akvt_chk u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
